/* rtl/per_sender_sequence_filter_macros.svh */
// assertion helpers shared by the filter
`ifndef PER_SENDER_SEQUENCE_FILTER_MACROS_SVH
`define PER_SENDER_SEQUENCE_FILTER_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define PSF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("per_sender_sequence_filter: check failed");

// next-cycle implication, quiet while reset is high
`define PSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("per_sender_sequence_filter: check failed");

`endif

/* rtl/psf_pkg.sv */
package psf_pkg;

   typedef enum logic [2:0] {
      VERDICT_DELIVER   = 3'd0,
      VERDICT_UNICAST   = 3'd1,
      VERDICT_MULTICAST = 3'd2,
      VERDICT_NODEST    = 3'd3,
      VERDICT_LATE      = 3'd4,
      VERDICT_CODED     = 3'd5
   } verdict_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MY_HOST       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MY_PORT       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_FLOOR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_CEILING = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNASSIGNED_ID = 3'd4;

   localparam logic [7:0] RESET_FLOOR_DEFAULT   = 8'd200;
   localparam logic [7:0] RESET_CEILING_DEFAULT = 8'd50;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic lookup;
      logic decide;
   } psf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } psf_status_type;

endpackage

/* rtl/psf_ram.sv */
module psf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/psf_ctrl.sv */
module psf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  psf_pkg::psf_status_type status,
   output psf_pkg::psf_cmd_type    cmd
);
   import psf_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      accept;

   assign accept = req_valid && req_ready_ff;

   always_comb begin
      state_in       = state_ff;
      req_ready_in   = req_ready_ff;
      cmd.clear_step = 1'b0;
      cmd.lookup     = 1'b0;
      cmd.decide     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         ST_IDLE: begin
            cmd.lookup = accept;
            if (accept) begin
               state_in     = ST_DECIDE;
               req_ready_in = 1'b0;
            end
         end
         ST_DECIDE: begin
            // wait here while the previous verdict is still unclaimed
            cmd.decide = status.rsp_free;
            if (status.rsp_free) begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_CLEAR;
            req_ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

/* rtl/psf_datapath.sv */
module psf_datapath #(
   parameter int SENDERS    = 256,
   parameter int ORDER_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [psf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [psf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_has_destination,
   input  logic [31:0]                          req_dest_host,
   input  logic [15:0]                          req_dest_port,
   input  logic [31:0]                          req_src_host,
   input  logic [15:0]                          req_src_port,
   input  logic [7:0]                           req_sender_id,
   input  logic [7:0]                           req_ordering,
   input  logic                                 req_empty_payload,
   input  logic                                 req_multi_packet,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_verdict,
   output logic                                 rsp_clear_pool,
   input  psf_pkg::psf_cmd_type                 cmd,
   output psf_pkg::psf_status_type              status
);
   import psf_pkg::*;

   localparam int IW    = $clog2(SENDERS);
   localparam int EXT_W = (ORDER_BITS > 8) ? ORDER_BITS : 8;
   localparam int IDS   = 256;

   // settings
   logic [31:0] my_host_ff;
   logic [15:0] my_port_ff;
   logic [7:0]  reset_floor_ff;
   logic [7:0]  reset_ceiling_ff;
   logic [7:0]  unassigned_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_host_ff       <= '0;
         my_port_ff       <= '0;
         reset_floor_ff   <= RESET_FLOOR_DEFAULT;
         reset_ceiling_ff <= RESET_CEILING_DEFAULT;
         unassigned_id_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MY_HOST:       my_host_ff       <= csr_wdata;
            CSR_MY_PORT:       my_port_ff       <= csr_wdata[15:0];
            CSR_RESET_FLOOR:   reset_floor_ff   <= csr_wdata[7:0];
            CSR_RESET_CEILING: reset_ceiling_ff <= csr_wdata[7:0];
            CSR_UNASSIGNED_ID: unassigned_id_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sender id folded onto the table depth
   logic [IW-1:0] idx_lut [IDS];
   for (genvar g = 0; g < IDS; g++) begin : g_idx_lut
      assign idx_lut[g] = IW'(g % SENDERS);
   end

   logic [IW-1:0] idx_now;
   assign idx_now = idx_lut[req_sender_id];

   // ordering number masked to the stored width
   logic [EXT_W-1:0]      ord_ext, floor_ext, ceil_ext;
   logic [ORDER_BITS-1:0] ord_now, floor_m, ceil_m;
   assign ord_ext   = EXT_W'(req_ordering);
   assign floor_ext = EXT_W'(reset_floor_ff);
   assign ceil_ext  = EXT_W'(reset_ceiling_ff);
   assign ord_now   = ord_ext[ORDER_BITS-1:0];
   assign floor_m   = floor_ext[ORDER_BITS-1:0];
   assign ceil_m    = ceil_ext[ORDER_BITS-1:0];

   // captured header
   logic                  has_dest_ff;
   logic [31:0]           dest_host_ff;
   logic [15:0]           dest_port_ff;
   logic [31:0]           src_host_ff;
   logic [15:0]           src_port_ff;
   logic [7:0]            sid_ff;
   logic [IW-1:0]         idx_ff;
   logic [ORDER_BITS-1:0] ord_ff;
   logic                  empty_ff;
   logic                  coded_ff;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         has_dest_ff  <= req_has_destination;
         dest_host_ff <= req_dest_host;
         dest_port_ff <= req_dest_port;
         src_host_ff  <= req_src_host;
         src_port_ff  <= req_src_port;
         sid_ff       <= req_sender_id;
         idx_ff       <= idx_now;
         ord_ff       <= ord_now;
         empty_ff     <= req_empty_payload;
         coded_ff     <= req_multi_packet;
      end
   end

   // clearing sweep over the known bits
   logic [IW-1:0] clr_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + IW'(1);
      end
   end
   assign status.clear_last = (clr_cnt_ff == IW'(SENDERS - 1));

   // tables
   logic                  known_rd;
   logic [ORDER_BITS-1:0] last_rd;
   logic                  table_wr;
   logic                  known_we;
   logic [IW-1:0]         known_waddr;

   assign known_we    = cmd.clear_step || table_wr;
   assign known_waddr = cmd.clear_step ? clr_cnt_ff : idx_ff;

   psf_ram #(.WIDTH(1), .DEPTH(SENDERS)) u_known_ram (
      .clock   (clock),
      .wr_en   (known_we),
      .wr_addr (known_waddr),
      .wr_data (!cmd.clear_step),
      .rd_en   (cmd.lookup),
      .rd_addr (idx_now),
      .rd_data (known_rd)
   );

   psf_ram #(.WIDTH(ORDER_BITS), .DEPTH(SENDERS)) u_order_ram (
      .clock   (clock),
      .wr_en   (table_wr),
      .wr_addr (idx_ff),
      .wr_data (ord_ff),
      .rd_en   (cmd.lookup),
      .rd_addr (idx_now),
      .rd_data (last_rd)
   );

   // decision
   logic        addr_hit, src_zero, bypass, restart, late, for_me;
   verdict_type verdict_in;

   assign addr_hit = (dest_host_ff == my_host_ff) && (dest_port_ff == my_port_ff);
   assign src_zero = (src_host_ff == '0) && (src_port_ff == '0);
   assign for_me   = !coded_ff && has_dest_ff && addr_hit;
   // last_rd is only looked at once the sender is known
   assign bypass   = empty_ff || (sid_ff == unassigned_id_ff) || !known_rd;
   assign restart  = !bypass && (last_rd >= floor_m) && (ord_ff < ceil_m);
   assign late     = !bypass && !restart && (last_rd >= ord_ff);
   assign table_wr = cmd.decide && for_me && !late;

   always_comb begin
      if (coded_ff) begin
         verdict_in = VERDICT_CODED;
      end else if (!has_dest_ff) begin
         verdict_in = VERDICT_NODEST;
      end else if (!addr_hit) begin
         verdict_in = src_zero ? VERDICT_MULTICAST : VERDICT_UNICAST;
      end else if (late) begin
         verdict_in = VERDICT_LATE;
      end else begin
         verdict_in = VERDICT_DELIVER;
      end
   end

   // result word register
   logic        rsp_valid_ff;
   verdict_type rsp_verdict_ff;
   logic        rsp_clear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.decide) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_verdict_ff <= verdict_in;
         rsp_clear_ff   <= for_me && restart;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_clear_pool  = rsp_clear_ff;

endmodule

/* rtl/per_sender_sequence_filter.sv */
// Per-sender sequence filter: one packet header word in, one verdict word out.
// Each header goes through the accept cycle, which issues the sender table read,
// and then the decide state, which decides and writes the table back; a new
// header is taken only after the last one is decided. The verdict sits in
// an output register, so the next header is accepted while it waits; a second
// verdict waits in the decide cycle until the first is taken. After reset the
// known-sender bits are swept clear, one entry a cycle, over all SENDERS
// entries, with req_ready low; settings writes are taken throughout.
module per_sender_sequence_filter #(
   parameter int SENDERS    = 256,
   parameter int ORDER_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [psf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_has_destination,
   input  logic [31:0]                     req_dest_host,
   input  logic [15:0]                     req_dest_port,
   input  logic [31:0]                     req_src_host,
   input  logic [15:0]                     req_src_port,
   input  logic [7:0]                      req_sender_id,
   input  logic [7:0]                      req_ordering,
   input  logic                            req_empty_payload,
   input  logic                            req_multi_packet,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_verdict,
   output logic                            rsp_clear_pool
);
   import psf_pkg::*;

   psf_cmd_type    cmd;
   psf_status_type status;

   psf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   psf_datapath #(.SENDERS(SENDERS), .ORDER_BITS(ORDER_BITS)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_has_destination (req_has_destination),
      .req_dest_host       (req_dest_host),
      .req_dest_port       (req_dest_port),
      .req_src_host        (req_src_host),
      .req_src_port        (req_src_port),
      .req_sender_id       (req_sender_id),
      .req_ordering        (req_ordering),
      .req_empty_payload   (req_empty_payload),
      .req_multi_packet    (req_multi_packet),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_clear_pool      (rsp_clear_pool),
      .cmd                 (cmd),
      .status              (status)
   );

`include "per_sender_sequence_filter_macros.svh"

   // only one header in flight
   `PSF_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   // a pool clear only comes with a delivered word
   `PSF_ASSERT_IMP(a_clear_delivers, clock, reset, rsp_valid && rsp_clear_pool,
                   rsp_verdict == VERDICT_DELIVER)
   // a fresh verdict follows a decide cycle, never the idle state
   `PSF_ASSERT_IMP(a_rsp_after_decide, clock, reset, $rose(rsp_valid), $past(!req_ready))
   // the table write and the clearing sweep never meet
   `PSF_ASSERT_IMP(a_no_decide_in_sweep, clock, reset, cmd.clear_step,
                   !cmd.decide && !cmd.lookup)

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import psf_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_WORDS = 340;
   localparam int PHASES       = 5;
   localparam int HOLD_CYCLES  = 300;

   // an index that maps to no register
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic        has_destination;
      logic [31:0] dest_host;
      logic [15:0] dest_port;
      logic [31:0] src_host;
      logic [15:0] src_port;
      logic [7:0]  sender_id;
      logic [7:0]  ordering;
      logic        empty_payload;
      logic        multi_packet;
   } pkt_hdr_type;

   typedef struct packed {
      verdict_type verdict;
      logic        clear_pool;
   } verdict_word_type;

   typedef struct packed {
      pkt_hdr_type      hdr;
      logic             typed;
      verdict_word_type want;
   } plan_row_type;

   // directed words, all under the settings held after reset
   localparam plan_row_type DIRECTED [21] = '{
      '{'{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1},
        1'b1, '{VERDICT_CODED, 1'b0}},
      '{'{1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 8'h00, 8'h00, 1'b0, 1'b1},
        1'b1, '{VERDICT_CODED, 1'b0}},
      '{'{1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'h1, 16'h1, 8'd7, 8'd7, 1'b0, 1'b0},
        1'b1, '{VERDICT_NODEST, 1'b0}},
      '{'{1'b1, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'h0, 8'd7, 8'd7, 1'b0, 1'b0},
        1'b1, '{VERDICT_MULTICAST, 1'b0}},
      '{'{1'b1, 32'h0, 16'h8000, 32'h8000_0000, 16'h0, 8'd7, 8'd7, 1'b0, 1'b0},
        1'b1, '{VERDICT_UNICAST, 1'b0}},
      '{'{1'b1, 32'h1, 16'h0, 32'h0, 16'h1, 8'd7, 8'd7, 1'b0, 1'b0},
        1'b1, '{VERDICT_UNICAST, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'hC0A8_0001, 16'd4000, 8'd5, 8'd10, 1'b0, 1'b0},
        1'b1, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd10, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd9, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd11, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd3, 1'b1, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd250, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd49, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd255, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd5, 8'd50, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd100, 1'b0, 1'b0},
        1'b1, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd0, 8'd0, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd255, 8'd255, 1'b0, 1'b0},
        1'b1, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd255, 8'd0, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd255, 8'd0, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}},
      '{'{1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 8'd255, 8'd255, 1'b0, 1'b0},
        1'b0, '{VERDICT_DELIVER, 1'b0}}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_has_destination;
   logic [31:0]            req_dest_host;
   logic [15:0]            req_dest_port;
   logic [31:0]            req_src_host;
   logic [15:0]            req_src_port;
   logic [7:0]             req_sender_id;
   logic [7:0]             req_ordering;
   logic                   req_empty_payload;
   logic                   req_multi_packet;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [2:0]             rsp_verdict;
   logic                   rsp_clear_pool;

   // predictor copy of the settings and the sender table
   logic [31:0] cfg_host;
   logic [15:0] cfg_port;
   logic [7:0]  cfg_floor;
   logic [7:0]  cfg_ceiling;
   logic [7:0]  cfg_unassigned;
   logic [7:0]  seen_order [256];
   bit          sender_seen [256];

   verdict_word_type expected_verdicts [$];
   int          fail_count  = 0;
   int          cycle_count = 0;
   int          word_count  = 0;
   bit          hold_req    = 1'b0;
   bit          hold_active = 1'b0;
   bit          sender_calm = 1'b0;
   logic [7:0]  pool_base   = 8'd0;

   per_sender_sequence_filter dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_has_destination (req_has_destination),
      .req_dest_host       (req_dest_host),
      .req_dest_port       (req_dest_port),
      .req_src_host        (req_src_host),
      .req_src_port        (req_src_port),
      .req_sender_id       (req_sender_id),
      .req_ordering        (req_ordering),
      .req_empty_payload   (req_empty_payload),
      .req_multi_packet    (req_multi_packet),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_clear_pool      (rsp_clear_pool)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic verdict_word_type predict_verdict(pkt_hdr_type h);
      verdict_word_type r;
      logic             take;
      r.verdict    = VERDICT_DELIVER;
      r.clear_pool = 1'b0;
      take         = 1'b1;
      if (h.multi_packet) begin
         r.verdict = VERDICT_CODED;
      end else if (!h.has_destination) begin
         r.verdict = VERDICT_NODEST;
      end else if (h.dest_host != cfg_host || h.dest_port != cfg_port) begin
         r.verdict = (h.src_host == 32'd0 && h.src_port == 16'd0) ?
                     VERDICT_MULTICAST : VERDICT_UNICAST;
      end else begin
         if (h.empty_payload || h.sender_id == cfg_unassigned || !sender_seen[h.sender_id]) begin
            take = 1'b1;
         end else if (seen_order[h.sender_id] >= cfg_floor && h.ordering < cfg_ceiling) begin
            r.clear_pool = 1'b1;
         end else if (seen_order[h.sender_id] >= h.ordering) begin
            take = 1'b0;
         end
         if (take) begin
            seen_order[h.sender_id]  = h.ordering;
            sender_seen[h.sender_id] = 1'b1;
         end else begin
            r.verdict = VERDICT_LATE;
         end
      end
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // random filler above the register width
   function automatic logic [31:0] with_noise(logic [31:0] value, int width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 32'd1;
      return ($urandom & ~mask) | (value & mask);
   endfunction

   function automatic pkt_hdr_type random_header();
      pkt_hdr_type h;
      int          r;
      logic [7:0]  last;
      h.has_destination = 1'b1;
      h.dest_host       = cfg_host;
      h.dest_port       = cfg_port;
      h.src_host        = $urandom;
      h.src_port        = 16'($urandom);
      h.multi_packet    = 1'b0;
      h.empty_payload   = ($urandom_range(0, 15) == 0);
      h.ordering        = 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 5) h.sender_id = cfg_unassigned;
      else if (r < 75) h.sender_id = pool_base + 8'($urandom_range(0, 7));
      else h.sender_id = 8'($urandom);
      // keep chains going so the ordering checks get exercised
      if (sender_seen[h.sender_id]) begin
         last = seen_order[h.sender_id];
         r = $urandom_range(0, 99);
         if (r < 55) h.ordering = last + 8'($urandom_range(1, 4));
         else if (r < 72) h.ordering = last - 8'($urandom_range(0, 3));
         else if (r < 87 && last >= cfg_floor && cfg_ceiling != 8'd0)
            h.ordering = 8'($urandom_range(0, int'(cfg_ceiling) - 1));
      end
      if ($urandom_range(0, 4) == 0) begin
         h.multi_packet    = ($urandom_range(0, 3) == 0);
         h.has_destination = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1)) h.dest_host = $urandom;
         if ($urandom_range(0, 1)) h.dest_port = 16'($urandom);
         r = $urandom_range(0, 5);
         if (r < 2) begin
            h.src_host = 32'd0;
            h.src_port = 16'd0;
         end else if (r == 2) begin
            h.src_host = 32'd0;
         end else if (r == 3) begin
            h.src_port = 16'd0;
         end
      end
      return h;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_MY_HOST:       cfg_host       = value;
         CSR_MY_PORT:       cfg_port       = value[15:0];
         CSR_RESET_FLOOR:   cfg_floor      = value[7:0];
         CSR_RESET_CEILING: cfg_ceiling    = value[7:0];
         CSR_UNASSIGNED_ID: cfg_unassigned = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_header(input pkt_hdr_type h, input logic typed,
                              input verdict_word_type want);
      verdict_word_type predicted;
      int               gap;
      @(negedge clock);
      req_valid           = 1'b1;
      req_has_destination = h.has_destination;
      req_dest_host       = h.dest_host;
      req_dest_port       = h.dest_port;
      req_src_host        = h.src_host;
      req_src_port        = h.src_port;
      req_sender_id       = h.sender_id;
      req_ordering        = h.ordering;
      req_empty_payload   = h.empty_payload;
      req_multi_packet    = h.multi_packet;
      do @(posedge clock); while (!req_ready);
      predicted = predict_verdict(h);
      expected_verdicts.push_back(typed ? want : predicted);
      word_count++;
      if (word_count % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      // no gaps while the receiver holds off, so the block backs up
      gap = (sender_calm || hold_active) ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side
   initial begin
      int stall_left;
      int beats;
      bit calm;
      stall_left = 0;
      beats      = 0;
      calm       = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         beats++;
         if (beats % 80 == 0) calm = ($urandom_range(0, 3) == 0);
         if (hold_req) begin
            hold_req    = 1'b0;
            hold_active = 1'b1;
            rsp_ready   = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_active = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (!calm) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      verdict_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            fail_count++;
            $display("%0t: verdict word %0d/%0d with nothing expected",
                     $time, rsp_verdict, rsp_clear_pool);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_verdict !== want.verdict) begin
               fail_count++;
               $display("%0t: verdict expected %0d actual %0d",
                        $time, want.verdict, rsp_verdict);
            end
            if (rsp_clear_pool !== want.clear_pool) begin
               fail_count++;
               $display("%0t: clear_pool expected %0d actual %0d",
                        $time, want.clear_pool, rsp_clear_pool);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] host;
      logic [15:0] port;
      logic [7:0]  floor_v;
      logic [7:0]  ceiling_v;
      logic [7:0]  unassigned_v;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_MY_HOST;
      csr_wdata           = '0;
      req_valid           = 1'b0;
      req_has_destination = 1'b0;
      req_dest_host       = '0;
      req_dest_port       = '0;
      req_src_host        = '0;
      req_src_port        = '0;
      req_sender_id       = '0;
      req_ordering        = '0;
      req_empty_payload   = 1'b0;
      req_multi_packet    = 1'b0;
      cfg_host            = '0;
      cfg_port            = '0;
      cfg_floor           = RESET_FLOOR_DEFAULT;
      cfg_ceiling         = RESET_CEILING_DEFAULT;
      cfg_unassigned      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i])
         send_header(DIRECTED[i].hdr, DIRECTED[i].typed, DIRECTED[i].want);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         pool_base = 8'($urandom);
         case (p)
            0: begin
               host = $urandom; port = 16'($urandom);
               floor_v = RESET_FLOOR_DEFAULT; ceiling_v = RESET_CEILING_DEFAULT;
               unassigned_v = 8'($urandom);
            end
            1: begin
               host = '1; port = '1; floor_v = '1; ceiling_v = '1; unassigned_v = '1;
            end
            2: begin
               host = '0; port = '0; floor_v = '0; ceiling_v = '0; unassigned_v = '0;
            end
            3: begin
               host = $urandom; port = 16'($urandom);
               floor_v = 8'd0; ceiling_v = 8'hFF; unassigned_v = 8'($urandom);
            end
            default: begin
               host = $urandom; port = 16'($urandom);
               floor_v = 8'($urandom); ceiling_v = 8'($urandom);
               unassigned_v = 8'($urandom);
            end
         endcase
         if (p == PHASES - 1) write_csr(CSR_SPARE, $urandom);
         write_csr(CSR_MY_HOST, host);
         write_csr(CSR_MY_PORT, with_noise(32'(port), 16));
         write_csr(CSR_RESET_FLOOR, with_noise(32'(floor_v), 8));
         write_csr(CSR_RESET_CEILING, with_noise(32'(ceiling_v), 8));
         write_csr(CSR_UNASSIGNED_ID, with_noise(32'(unassigned_v), 8));
         for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (p == 0 && n == 120) hold_req = 1'b1;
            send_header(random_header(), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
